### hdl/lkvc_pkg.sv
package lkvc_pkg;

  // Default slot count and fixed field widths
  localparam int unsigned EntriesDefault = 16;
  localparam int unsigned CapacityW      = 5;
  localparam int unsigned DataW          = 32;

  // Capacity after reset
  localparam logic [CapacityW-1:0] CapacityReset = CapacityW'(16);

  // Request kinds
  localparam logic ReqGet = 1'b0;
  localparam logic ReqPut = 1'b1;

  // Read value returned on a get miss and on every put
  localparam logic signed [DataW-1:0] MissValue = '1;
  localparam logic signed [DataW-1:0] PutValue  = '0;

  typedef struct packed {
    logic                    req_type;
    logic signed [DataW-1:0] key;
    logic signed [DataW-1:0] value;
  } req_t;

  typedef struct packed {
    logic                    hit;
    logic signed [DataW-1:0] read_value;
  } rsp_t;

endpackage

### hdl/lkvc_table.sv
module lkvc_table #(
  parameter int unsigned ENTRIES = lkvc_pkg::EntriesDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  lkvc_pkg::req_t                 req_i,
  input  logic [lkvc_pkg::CapacityW-1:0] capacity_i,
  output lkvc_pkg::rsp_t                 rsp_o
);
  import lkvc_pkg::*;

  localparam int unsigned RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned UW = $clog2(ENTRIES + 1);

  // Slot storage: keys and values hold no reset, a slot is read only while valid
  logic signed [DataW-1:0] key_q   [ENTRIES];
  logic signed [DataW-1:0] value_q [ENTRIES];
  logic [ENTRIES-1:0]      valid_q;
  logic [RW-1:0]           rank_q  [ENTRIES];
  logic [UW-1:0]           used_q;

  logic [ENTRIES-1:0]      match;
  logic [ENTRIES-1:0]      victim;
  logic [ENTRIES-1:0]      valid_ev;
  logic [ENTRIES-1:0]      free_slot;
  logic                    hit;
  logic [RW-1:0]           hit_rank;
  logic signed [DataW-1:0] hit_value;
  logic [UW-1:0]           cap_eff;
  logic [RW-1:0]           oldest_rank;
  logic                    is_put;
  logic                    evict;
  logic                    insert;
  logic                    found;

  // Clamp capacity into 1 .. ENTRIES
  always_comb begin
    if (capacity_i == '0) begin
      cap_eff = UW'(1);
    end else if (32'(capacity_i) > 32'(ENTRIES)) begin
      cap_eff = UW'(ENTRIES);
    end else begin
      cap_eff = UW'(capacity_i);
    end
  end

  // Compare the key against every slot; valid keys are distinct
  always_comb begin
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_q[i] && (key_q[i] == req_i.key);
      if (match[i]) begin
        hit_rank  = hit_rank | rank_q[i];
        hit_value = hit_value | value_q[i];
      end
    end
    hit = |match;
  end

  // Pick the oldest slot, which holds rank used_count-1, and the lowest free slot
  assign is_put      = (req_i.req_type == ReqPut);
  assign oldest_rank = RW'(used_q - UW'(1));
  assign evict       = is_put && !hit && (used_q >= cap_eff);
  assign insert      = is_put && !hit;

  always_comb begin
    found = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      victim[i]    = valid_q[i] && (rank_q[i] == oldest_rank);
      valid_ev[i]  = valid_q[i] && !(evict && victim[i]);
      free_slot[i] = 1'b0;
      if (!valid_ev[i] && !found) begin
        free_slot[i] = 1'b1;
        found        = 1'b1;
      end
    end
  end

  // Update valid bits, recency ranks and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      used_q  <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (accept_i) begin
      if (hit) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (match[i]) begin
            rank_q[i] <= '0;
          end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
            rank_q[i] <= rank_q[i] + RW'(1);
          end
        end
      end else if (insert) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (free_slot[i]) begin
            valid_q[i] <= 1'b1;
            rank_q[i]  <= '0;
          end else if (valid_ev[i]) begin
            rank_q[i] <= rank_q[i] + RW'(1);
          end else begin
            valid_q[i] <= 1'b0;
          end
        end
        if (!evict) begin
          used_q <= used_q + UW'(1);
        end
      end
    end
  end

  // Write key and value on insert, value on put hit
  always_ff @(posedge clk_i) begin
    if (accept_i && is_put) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit ? match[i] : free_slot[i]) begin
          key_q[i]   <= req_i.key;
          value_q[i] <= req_i.value;
        end
      end
    end
  end

  // Form the result of this transaction
  always_comb begin
    rsp_o.hit = hit;
    if (is_put) begin
      rsp_o.read_value = PutValue;
    end else if (hit) begin
      rsp_o.read_value = hit_value;
    end else begin
      rsp_o.read_value = MissValue;
    end
  end

endmodule

### hdl/lru_key_value_cache_unit.sv
// Fully associative key/value cache of ENTRIES slots with least-recently-used
// replacement. Each request (get or put) is handled as a whole on acceptance:
// all slot keys are compared in parallel and all recency ranks are updated
// together, so one transaction is accepted every clock unless a held result
// stalls the output register, and its result appears in that register on the
// next cycle. A put that misses while the fill count has reached the capacity
// evicts the least recent pair first. The user must write capacity through
// cfg_we_i/cfg_wdata_i only while idle; the block does not enforce it. Zero
// acts as one, values above ENTRIES act as ENTRIES. Reset empties the cache.
module lru_key_value_cache_unit #(
  parameter int unsigned ENTRIES = lkvc_pkg::EntriesDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           req_valid_i,
  output logic                           req_ready_o,
  input  lkvc_pkg::req_t                 req_i,
  output logic                           rsp_valid_o,
  input  logic                           rsp_ready_i,
  output lkvc_pkg::rsp_t                 rsp_o,
  input  logic                           cfg_we_i,
  input  logic [lkvc_pkg::CapacityW-1:0] cfg_wdata_i
);
  import lkvc_pkg::*;

  logic [CapacityW-1:0] capacity_q;
  logic                 rsp_valid_q;
  rsp_t                 rsp_q;
  rsp_t                 rsp_d;
  logic                 accept;

  // Take a new transaction while the output register is empty or draining
  assign req_ready_o = !rsp_valid_q || rsp_ready_i;
  assign accept      = req_valid_i && req_ready_o;

  // Hold the capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CapacityReset;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  lkvc_table #(
    .ENTRIES (ENTRIES)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_i      (req_i),
    .capacity_i (capacity_q),
    .rsp_o      (rsp_d)
  );

  // Track output occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (accept) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  // Capture the result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

### verif/tb_lru_key_value_cache_unit.sv
module tb_lru_key_value_cache_unit;
  import lkvc_pkg::*;

  localparam int Entries     = EntriesDefault;
  localparam int PhaseItems  = 130;
  localparam int LongHold    = 60;
  localparam int DrainCycles = 4;

  typedef enum int {IdleNone, IdleSend, IdleRecv, IdleBoth} idle_mode_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 req_valid_i = 1'b0;
  logic                 req_ready_o;
  req_t                 req_i = '0;
  logic                 rsp_valid_o;
  logic                 rsp_ready_i = 1'b0;
  rsp_t                 rsp_o;
  logic                 cfg_we_i = 1'b0;
  logic [CapacityW-1:0] cfg_wdata_i = '0;

  // Shadow copy of the cache contents and the capacity register
  logic signed [DataW-1:0] slot_key   [Entries];
  logic signed [DataW-1:0] slot_value [Entries];
  logic                    slot_valid [Entries];
  logic [3:0]              slot_rank  [Entries];
  logic [4:0]              used_slots;
  logic [CapacityW-1:0]    capacity_shadow;

  rsp_t expected_rsp_q [$];
  rsp_t oldest_rsp;
  int   mismatch_count = 0;

  // Idle control shared by sender and receiver
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;

  // Keys reused within a phase so that lookups hit and puts evict
  logic signed [DataW-1:0] key_pool [24];
  int                      pool_size = 2;

  lru_key_value_cache_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Make one slot the most recent; newer valid slots age by one
  function automatic void promote_slot(input int s);
    for (int i = 0; i < Entries; i++) begin
      if (slot_valid[i] && i != s && slot_rank[i] < slot_rank[s]) slot_rank[i]++;
    end
    slot_rank[s] = '0;
  endfunction

  // Apply one request to the shadow cache and return its lookup result
  function automatic rsp_t lru_access(input req_t r);
    rsp_t       res;
    int         hit_slot;
    int         victim;
    int         free_slot;
    logic [3:0] oldest;
    logic [4:0] eff_cap;
    hit_slot = -1;
    for (int i = 0; i < Entries; i++) begin
      if (hit_slot < 0 && slot_valid[i] && slot_key[i] == r.key) hit_slot = i;
    end
    res.hit = (hit_slot >= 0);
    res.read_value = PutValue;
    if (r.req_type == ReqGet) begin
      if (res.hit) begin
        res.read_value = slot_value[hit_slot];
        promote_slot(hit_slot);
      end else begin
        res.read_value = MissValue;
      end
    end else if (res.hit) begin
      slot_value[hit_slot] = r.value;
      promote_slot(hit_slot);
    end else begin
      eff_cap = capacity_shadow;
      if (eff_cap == 5'd0) eff_cap = 5'd1;
      if (eff_cap > Entries) eff_cap = 5'(Entries);
      // Evict only the single least recent pair, even above capacity
      if (used_slots >= eff_cap) begin
        victim = -1;
        oldest = '0;
        for (int i = 0; i < Entries; i++) begin
          if (slot_valid[i] && (victim < 0 || slot_rank[i] >= oldest)) begin
            oldest = slot_rank[i];
            victim = i;
          end
        end
        if (victim >= 0) begin
          slot_valid[victim] = 1'b0;
          slot_rank[victim]  = '0;
          used_slots--;
        end
      end
      // Insert into the lowest free slot as most recent
      free_slot = -1;
      for (int i = Entries - 1; i >= 0; i--) begin
        if (!slot_valid[i]) free_slot = i;
      end
      if (free_slot >= 0) begin
        for (int i = 0; i < Entries; i++) begin
          if (slot_valid[i]) slot_rank[i]++;
        end
        slot_key[free_slot]   = r.key;
        slot_value[free_slot] = r.value;
        slot_valid[free_slot] = 1'b1;
        slot_rank[free_slot]  = '0;
        used_slots++;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Track config writes and accepted requests, then check each result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) capacity_shadow = cfg_wdata_i;
      if (req_valid_i && req_ready_o) expected_rsp_q.push_back(lru_access(req_i));
      if (rsp_valid_o && rsp_ready_i) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("result transaction with no request outstanding");
        end else begin
          oldest_rsp = expected_rsp_q.pop_front();
          if (rsp_o.hit !== oldest_rsp.hit)
            report_mismatch($sformatf("hit got %b want %b", rsp_o.hit, oldest_rsp.hit));
          if (rsp_o.read_value !== oldest_rsp.read_value)
            report_mismatch($sformatf("read_value got %h want %h",
                                      rsp_o.read_value, oldest_rsp.read_value));
        end
      end
    end
  end

  // Drive the result ready: random stalls, or a long hold on request
  always @(posedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = LongHold;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready_i <= 1'b0;
    end else begin
      rsp_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic req_t make_req(input logic kind, input logic [31:0] k,
                                    input logic [31:0] v);
    req_t r;
    r.req_type = kind;
    r.key      = k;
    r.value    = v;
    return r;
  endfunction

  // Offer one request, with random idle cycles ahead of it, and hold it until accepted
  task automatic send_req(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i       <= r;
    @(posedge clk_i);
    while (!req_ready_o) @(posedge clk_i);
  endtask

  // Stop offering and wait until every outstanding result has come back
  task automatic wait_idle();
    req_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CapacityW-1:0] c);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= c;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      IdleNone: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IdleSend: begin send_idle_pct = 59; recv_stall_pct = 0;  end
      IdleRecv: begin send_idle_pct = 0;  recv_stall_pct = 59; end
      default:  begin send_idle_pct = 17; recv_stall_pct = 17; end
    endcase
  endtask

  function automatic req_t random_req();
    req_t r;
    r.req_type = 1'($urandom_range(1));
    r.key      = ($urandom_range(99) < 80) ? key_pool[$urandom_range(pool_size - 1)]
                                           : $urandom;
    r.value    = $urandom;
    return r;
  endfunction

  task automatic refill_key_pool();
    pool_size = $urandom_range(24, 2);
    for (int i = 0; i < 24; i++) key_pool[i] = $urandom;
    if ($urandom_range(1)) key_pool[0] = 32'h8000_0000;
    if ($urandom_range(1)) key_pool[1] = 32'h7fff_ffff;
  endtask

  // Empty cache, extreme keys and values, update of a present key
  task automatic test_empty_and_extremes();
    set_idle(IdleNone);
    send_req(make_req(ReqGet, 32'h0000_0000, 32'hffff_ffff));
    send_req(make_req(ReqPut, 32'h8000_0000, 32'h7fff_ffff));
    send_req(make_req(ReqPut, 32'h7fff_ffff, 32'h8000_0000));
    send_req(make_req(ReqPut, 32'hffff_ffff, 32'hffff_ffff));
    send_req(make_req(ReqPut, 32'h0000_0000, 32'h0000_0000));
    send_req(make_req(ReqGet, 32'h8000_0000, 32'h0000_0000));
    send_req(make_req(ReqGet, 32'h7fff_ffff, 32'hffff_ffff));
    send_req(make_req(ReqGet, 32'hffff_ffff, 32'h1234_5678));
    send_req(make_req(ReqGet, 32'h0000_0000, 32'h0000_0000));
    send_req(make_req(ReqGet, 32'h0000_0001, 32'h0000_0000));
    send_req(make_req(ReqPut, 32'hffff_ffff, 32'h0000_0005));
    send_req(make_req(ReqGet, 32'hffff_ffff, 32'h0000_0000));
  endtask

  // Lower capacity below the fill count: a miss evicts one pair only
  task automatic test_capacity_shrink();
    write_capacity(2);
    send_req(make_req(ReqPut, 32'h0000_0064, 32'h0000_00aa));
    send_req(make_req(ReqGet, 32'h8000_0000, 32'h0000_0000));
    send_req(make_req(ReqGet, 32'h7fff_ffff, 32'h0000_0000));
  endtask

  // Capacity zero acts as one
  task automatic test_capacity_zero();
    write_capacity(0);
    send_req(make_req(ReqPut, 32'h0000_00c8, 32'h0000_0001));
    send_req(make_req(ReqPut, 32'h0000_00c9, 32'h0000_0002));
    send_req(make_req(ReqGet, 32'h0000_00c8, 32'h0000_0000));
  endtask

  // Capacity above the slot count saturates
  task automatic test_capacity_saturate();
    write_capacity(31);
    send_req(make_req(ReqPut, 32'h0000_012c, 32'h0000_0003));
    send_req(make_req(ReqPut, 32'h0000_012d, 32'h0000_0004));
    send_req(make_req(ReqGet, 32'h0000_012c, 32'h0000_0000));
  endtask

  // Hold off results so the block backs up, then pause the sender until drained
  task automatic test_receiver_hold();
    write_capacity(4);
    set_idle(IdleNone);
    refill_key_pool();
    hold_requests++;
    repeat (40) send_req(random_req());
    wait_idle();
    repeat (20) send_req(random_req());
  endtask

  task automatic test_random_phases();
    logic [CapacityW-1:0] phase_cap [8];
    phase_cap = '{16, 1, 31, 0, 3, 8, 17, 5};
    phase_cap[7] = CapacityW'($urandom_range(31));
    for (int p = 0; p < 8; p++) begin
      write_capacity(phase_cap[p]);
      set_idle(idle_mode_e'(p % 4));
      refill_key_pool();
      repeat (PhaseItems) send_req(random_req());
    end
  endtask

  initial begin
    for (int i = 0; i < Entries; i++) begin
      slot_key[i]   = '0;
      slot_value[i] = '0;
      slot_valid[i] = 1'b0;
      slot_rank[i]  = '0;
    end
    used_slots      = '0;
    capacity_shadow = CapacityReset;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_extremes();
    test_capacity_shrink();
    test_capacity_zero();
    test_capacity_saturate();
    test_receiver_hold();
    test_random_phases();
    wait_idle();

    if (mismatch_count == 0) begin
      $display("lru_key_value_cache_unit: match");
    end else begin
      $display("lru_key_value_cache_unit: mismatch");
    end
    $finish;
  end

  // Bound the run in case the block hangs
  initial begin
    #2000000;
    $display("lru_key_value_cache_unit: mismatch");
    $finish;
  end

endmodule
